FILE: rtl/hrd_pkg.sv
// ============================================================================
// Hamming row decoder package
// Shared widths, register map, result type and row-geometry helpers.
// ============================================================================
package hrd_pkg;

    localparam int CW_W               = 62;
    localparam int DATA_W             = 56;
    localparam int SYN_W              = 6;
    localparam int BYTES_W            = 3;
    localparam int ROW_LEN_W          = 6;
    localparam int PDATA_W            = 32;
    localparam int PADDR_W            = 3;
    localparam int DEF_MAX_DATA_BYTES = 7;

    localparam logic [BYTES_W-1:0] DATA_BYTES_RESET = BYTES_W'(1);

    // Register word indexes (byte address divided by four).
    localparam logic REG_DATA_BYTES = 1'b0;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [SYN_W-1:0]  syndrome;
        logic              corrected;
        logic              out_of_range;
    } hrd_result_t;

    // Length of a row in positions: 8*bytes data bits plus the check bits.
    function automatic logic [ROW_LEN_W-1:0] row_len(input logic [BYTES_W-1:0] bytes);
        logic [ROW_LEN_W-1:0] len;
        unique case (bytes)
            3'd1:    len = ROW_LEN_W'(12);
            3'd2:    len = ROW_LEN_W'(21);
            3'd3:    len = ROW_LEN_W'(29);
            3'd4:    len = ROW_LEN_W'(38);
            3'd5:    len = ROW_LEN_W'(46);
            3'd6:    len = ROW_LEN_W'(54);
            default: len = ROW_LEN_W'(62);
        endcase
        return len;
    endfunction

    // Codeword position (from 1) of the d-th data bit, counting from 0.
    // Only evaluated with constant arguments.
    function automatic int data_pos(input int d);
        int seen;
        int pos;
        seen = 0;
        pos  = 0;
        for (int k = 1; k <= CW_W; k++) begin
            if ((k & (k - 1)) != 0) begin
                if (seen == d) begin
                    pos = k;
                end
                seen++;
            end
        end
        return pos;
    endfunction

endpackage

FILE: rtl/hrd_cfg_regs.sv
// ============================================================================
// Hamming row decoder configuration registers
// APB-style register file holding the data byte count of a row.
// ============================================================================
module hrd_cfg_regs
    import hrd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    output logic [BYTES_W-1:0]  data_bytes
);

    logic                 wr_en;
    logic [BYTES_W-1:0]   data_bytes_reg;
    logic [BYTES_W-1:0]   data_bytes_next;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        data_bytes_next = data_bytes_reg;
        if (wr_en && (paddr[2] == REG_DATA_BYTES))
        begin
            data_bytes_next = pwdata[BYTES_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_bytes_reg <= DATA_BYTES_RESET;
        end
        else
        begin
            data_bytes_reg <= data_bytes_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_DATA_BYTES)
        begin
            prdata = PDATA_W'(data_bytes_reg);
        end
    end

    assign data_bytes = data_bytes_reg;

endmodule

FILE: rtl/hrd_decode.sv
// ============================================================================
// Hamming row decoder core
// Syndrome parity trees, single-bit correction and data bit extraction.
// ============================================================================
module hrd_decode
    import hrd_pkg::*;
#(
    parameter int MAX_DATA_BYTES = DEF_MAX_DATA_BYTES
)
(
    input  logic [CW_W-1:0]    codeword,
    input  logic [BYTES_W-1:0] data_bytes,
    output hrd_result_t        result
);

    logic [BYTES_W-1:0]   eff_bytes;
    logic [ROW_LEN_W-1:0] n_len;
    logic [CW_W-1:0]      cw_mask;
    logic [CW_W-1:0]      cw_fix;
    logic [SYN_W-1:0]     syn;
    logic                 fix;
    logic                 oor;
    logic [DATA_W-1:0]    packed_bits;
    logic [5:0]           shamt;

    // Zero bytes counts as one, anything above the maximum is clamped.
    always_comb
    begin
        eff_bytes = data_bytes;
        if (data_bytes == '0)
        begin
            eff_bytes = BYTES_W'(1);
        end
        else if (data_bytes > BYTES_W'(MAX_DATA_BYTES))
        begin
            eff_bytes = BYTES_W'(MAX_DATA_BYTES);
        end
    end

    assign n_len = row_len(eff_bytes);

    always_comb
    begin
        for (int i = 0; i < CW_W; i++)
        begin
            cw_mask[i] = codeword[i] && (ROW_LEN_W'(i) < n_len);
        end
        syn = '0;
        for (int j = 0; j < SYN_W; j++)
        begin
            for (int k = 1; k <= CW_W; k++)
            begin
                if (((k >> j) & 1) != 0)
                begin
                    syn[j] = syn[j] ^ cw_mask[k-1];
                end
            end
        end
        fix = (syn != '0) && (syn <= n_len);
        oor = (syn != '0) && (syn > n_len);
        for (int i = 0; i < CW_W; i++)
        begin
            cw_fix[i] = cw_mask[i] ^ (fix && (syn == SYN_W'(i + 1)));
        end
    end

    // Data bits in order, first data bit at the top.
    for (genvar d = 0; d < DATA_W; d++)
    begin : g_pack
        localparam int POS = data_pos(d);
        assign packed_bits[DATA_W-1-d] = cw_fix[POS-1];
    end

    assign shamt = 6'(DATA_W) - {eff_bytes, 3'b000};

    assign result.data         = packed_bits >> shamt;
    assign result.syndrome     = syn;
    assign result.corrected    = fix;
    assign result.out_of_range = oor;

endmodule

FILE: rtl/hamming_row_decoder_corrector.sv
// ============================================================================
// Hamming row decoder and corrector
// Single-error-correcting decoder for one codeword row per transaction.
// ============================================================================
// A codeword row enters on the input channel (in_valid, in_stall, codeword)
// and one result leaves on the output channel (out_valid, out_stall, data,
// syndrome, corrected, out_of_range) for every input transaction.
// The row length follows the data_bytes register, written over the APB-style
// port at byte address 0; it should only be changed while the block is idle.
// A row taken from the input channel is held in the input register, and
// its result in the result register. The decode between the two registers
// is one pass of parity trees, a correcting XOR and a byte-granular shift,
// so a new row is accepted on every cycle in which in_stall is low.
// When the receiver stalls, the result register holds its transaction and
// the input register may still take one more row; in_stall rises only once
// both are full. On reset both stages empty and data_bytes returns to one.
// ============================================================================
module hamming_row_decoder_corrector
    import hrd_pkg::*;
#(
    parameter int MAX_DATA_BYTES = DEF_MAX_DATA_BYTES
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [CW_W-1:0]     codeword,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [DATA_W-1:0]   data,
    output logic [SYN_W-1:0]    syndrome,
    output logic                corrected,
    output logic                out_of_range
);

    logic [BYTES_W-1:0] data_bytes;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [CW_W-1:0]    s1_cw_reg;
    logic [CW_W-1:0]    s1_cw_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    hrd_result_t        out_res_reg;
    hrd_result_t        out_res_next;
    hrd_result_t        dec_res;

    logic               out_adv;
    logic               in_acc;

    hrd_cfg_regs u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .data_bytes (data_bytes)
    );

    hrd_decode #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_decode (
        .codeword   (s1_cw_reg),
        .data_bytes (data_bytes),
        .result     (dec_res)
    );

    // The result register moves whenever it is empty or being taken.
    assign out_adv  = !out_valid_reg || !out_stall;
    // The input register only blocks when it is full and cannot drain.
    assign in_stall = s1_valid_reg && !out_adv;
    assign in_acc   = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_cw_next     = s1_cw_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (in_acc)
        begin
            s1_valid_next = 1'b1;
            s1_cw_next    = codeword;
        end
        else if (out_adv)
        begin
            s1_valid_next = 1'b0;
        end
        if (out_adv)
        begin
            out_valid_next = s1_valid_reg;
            if (s1_valid_reg)
            begin
                out_res_next = dec_res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        s1_cw_reg   <= s1_cw_next;
        out_res_reg <= out_res_next;
    end

    assign out_valid    = out_valid_reg;
    assign data         = out_res_reg.data;
    assign syndrome     = out_res_reg.syndrome;
    assign corrected    = out_res_reg.corrected;
    assign out_of_range = out_res_reg.out_of_range;

endmodule

FILE: rtl/hrd_checker.sv
// ============================================================================
// Hamming row decoder port checker
// Concurrent assertions on the top level's ports, bound to the top level.
// ============================================================================
module hrd_checker
    import hrd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_stall,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [DATA_W-1:0]  data,
    input  logic [SYN_W-1:0]   syndrome,
    input  logic               corrected,
    input  logic               out_of_range
);

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(data) && $stable(syndrome)
            && $stable(corrected) && $stable(out_of_range))
        else $error("stalled result changed");

    // The input side is only held off while a result is waiting.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with free result stage");

    // A correction and an out-of-range flag exclude each other.
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(corrected && out_of_range))
        else $error("corrected and out_of_range both set");

    // A clean row neither corrects nor flags.
    a_zero_syn: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (syndrome == '0) |-> !corrected && !out_of_range)
        else $error("flag set with zero syndrome");

    // The shortest row has twelve positions, so smaller syndromes always fit.
    a_oor_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> syndrome > SYN_W'(12))
        else $error("out_of_range on a syndrome inside every row");

endmodule

bind hamming_row_decoder_corrector hrd_checker u_hrd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .data         (data),
    .syndrome     (syndrome),
    .corrected    (corrected),
    .out_of_range (out_of_range)
);
